>>> sv/pmte_pkg.sv
package pmte_pkg;

    // Default table depth and register reset value.
    localparam int DEFAULT_ENTRIES = 8;
    localparam logic [15:0] MAX_AGE_RESET = 16'd1000;

    // Byte address of the max_age register on the configuration port.
    localparam logic [1:0] ADDR_MAX_AGE = 2'd0;

    // Entry kinds.
    localparam logic KIND_CTRL  = 1'b0;
    localparam logic KIND_PROXY = 1'b1;

    typedef enum logic [2:0] {
        REQ_STORE_CTRL  = 3'd0,
        REQ_STORE_PROXY = 3'd1,
        REQ_FIND        = 3'd2,
        REQ_REMOVE      = 3'd3,
        REQ_CLEAR       = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ID_ORIG = 2'd0,
        ID_NEW  = 2'd1,
        ID_ECHO = 2'd2
    } id_sel_t;

    typedef enum logic [2:0] {
        STAT_FOUND     = 3'd0,
        STAT_STORED    = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_DONE      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_SCAN,
        S_DECIDE,
        S_STORE,
        S_REMOVE,
        S_CLEAR,
        S_NOP
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    cnt_clear;
        logic    sweep_step;
        logic    scan_step;
        logic    insert;
        logic    remove;
        logic    clear;
        logic    finish;
        logic    use_entry;
        logic    use_free;
        status_t status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic found;
        logic have_free;
    } sts_t;

endpackage

>>> sv/pmte_apb.sv
module pmte_apb
    import pmte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] max_age
);

    logic [15:0] max_age_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_age_reg <= MAX_AGE_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_MAX_AGE))
        begin
            max_age_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        if (paddr == ADDR_MAX_AGE)
        begin
            prdata = {16'd0, max_age_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    assign pready  = 1'b1;
    assign max_age = max_age_reg;

endmodule

>>> sv/pmte_ctrl.sv
module pmte_ctrl
    import pmte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] req_type,
    input  sts_t       sts,
    output cmd_t       cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;
    logic   find_reg;
    logic   find_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            find_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            find_reg  <= find_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        find_next  = find_reg;
        cmd        = '0;
        cmd.status = STAT_DONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load      = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    find_next     = (req_type == REQ_FIND);
                    case (req_type)
                        REQ_STORE_CTRL,
                        REQ_STORE_PROXY,
                        REQ_FIND:   state_next = S_SWEEP;
                        REQ_REMOVE: state_next = S_REMOVE;
                        REQ_CLEAR:  state_next = S_CLEAR;
                        default:    state_next = S_NOP;
                    endcase
                end
            end
            S_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.last)
                begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.found)
                begin
                    cmd.finish    = 1'b1;
                    cmd.use_entry = 1'b1;
                    cmd.status    = STAT_FOUND;
                    state_next    = S_IDLE;
                end
                else if (find_reg)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = STAT_NOT_FOUND;
                    state_next = S_IDLE;
                end
                else if (sts.have_free)
                begin
                    cmd.insert = 1'b1;
                    state_next = S_STORE;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.status = STAT_FULL;
                    state_next = S_IDLE;
                end
            end
            S_STORE:
            begin
                cmd.finish    = 1'b1;
                cmd.use_entry = 1'b1;
                cmd.use_free  = 1'b1;
                cmd.status    = STAT_STORED;
                state_next    = S_IDLE;
            end
            S_REMOVE:
            begin
                cmd.remove = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_CLEAR:
            begin
                cmd.clear  = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_NOP:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> sv/pmte_dp.sv
module pmte_dp
    import pmte_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [2:0]  req_type,
    input  logic [15:0] now,
    input  logic        msg_kind,
    input  logic [15:0] msg_id,
    input  logic [1:0]  id_index,
    input  logic [1:0]  coap_type,
    input  logic [2:0]  slot,
    input  logic [15:0] max_age,
    output logic        done,
    output logic [2:0]  status,
    output logic [2:0]  hit_slot,
    output logic        entry_kind,
    output logic [1:0]  entry_coap_type,
    output logic [15:0] entry_original_id,
    output logic [15:0] entry_new_id,
    output logic [15:0] entry_echoed_id
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Table storage.
    logic             valid_reg    [ENTRIES];
    logic             kind_tab_reg [ENTRIES];
    logic [1:0]       coap_tab_reg [ENTRIES];
    logic [15:0]      first_reg    [ENTRIES];
    logic [15:0]      assigned_reg [ENTRIES];
    logic [15:0]      echo_reg     [ENTRIES];
    logic [15:0]      stamp_reg    [ENTRIES];
    logic [IDX_W-1:0] order_reg    [ENTRIES];
    logic [15:0]      id_counter_reg;

    // Request captured at accept.
    logic             kind_reg;
    logic [15:0]      id_reg;
    logic [1:0]       idx_reg;
    logic [1:0]       coap_reg;
    logic [15:0]      now_reg;
    logic [2:0]       slot_reg;
    logic             proxy_reg;

    // Walk state.
    logic [IDX_W-1:0] cnt_reg;
    logic             found_reg;
    logic [IDX_W-1:0] best_reg;
    logic [IDX_W-1:0] best_rank_reg;
    logic             have_free_reg;
    logic [IDX_W-1:0] free_reg;
    logic [CNT_W-1:0] used_reg;

    // Result registers.
    logic             done_reg;
    logic [2:0]       status_reg;
    logic [2:0]       hit_slot_reg;
    logic             kind_out_reg;
    logic [1:0]       coap_out_reg;
    logic [15:0]      orig_out_reg;
    logic [15:0]      new_out_reg;
    logic [15:0]      echo_out_reg;

    logic [15:0]      age;
    logic             expired;
    logic [15:0]      picked_id;
    logic             idx_ok;
    logic             match;
    logic             better;
    logic [IDX_W-1:0] slot_idx;
    logic             slot_ok;
    logic             free_en;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] free_rank;
    logic [IDX_W-1:0] sel;

    assign age     = now_reg - stamp_reg[cnt_reg];
    assign expired = valid_reg[cnt_reg] && (age > max_age);

    always_comb
    begin
        case (idx_reg)
            ID_ORIG: picked_id = first_reg[cnt_reg];
            ID_NEW:  picked_id = assigned_reg[cnt_reg];
            ID_ECHO: picked_id = echo_reg[cnt_reg];
            default: picked_id = 16'd0;
        endcase
    end

    assign idx_ok = (idx_reg == ID_ORIG) || (idx_reg == ID_NEW) || (idx_reg == ID_ECHO);
    assign match  = valid_reg[cnt_reg] && (kind_tab_reg[cnt_reg] == kind_reg) && idx_ok
                    && (picked_id == id_reg);
    assign better = !found_reg || (order_reg[cnt_reg] < best_rank_reg);

    assign slot_idx  = IDX_W'(slot_reg);
    assign slot_ok   = (int'(slot_reg) < ENTRIES);
    assign free_idx  = cmd.remove ? slot_idx : cnt_reg;
    assign free_en   = (cmd.sweep_step && expired)
                       || (cmd.remove && slot_ok && valid_reg[slot_idx]);
    assign free_rank = order_reg[free_idx];
    assign sel       = cmd.use_free ? free_reg : best_reg;

    assign sts.last      = (cnt_reg == IDX_W'(ENTRIES - 1));
    assign sts.found     = found_reg;
    assign sts.have_free = have_free_reg;

    // Control state: valid bits, ID counter, walk trackers and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            id_counter_reg <= 16'd0;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            have_free_reg  <= 1'b0;
            used_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.cnt_clear)
            begin
                cnt_reg       <= '0;
                found_reg     <= 1'b0;
                have_free_reg <= 1'b0;
                used_reg      <= '0;
            end
            else if (cmd.sweep_step || cmd.scan_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.scan_step)
            begin
                if (match && better)
                begin
                    found_reg <= 1'b1;
                end
                if (valid_reg[cnt_reg])
                begin
                    used_reg <= used_reg + 1'b1;
                end
                else
                begin
                    have_free_reg <= 1'b1;
                end
            end
            if (free_en)
            begin
                valid_reg[free_idx] <= 1'b0;
            end
            if (cmd.insert)
            begin
                valid_reg[free_reg] <= 1'b1;
                if (proxy_reg)
                begin
                    id_counter_reg <= id_counter_reg + 16'd1;
                end
            end
            if (cmd.clear)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    valid_reg[i] <= 1'b0;
                end
            end
        end
    end

    // Payload: captured request, table contents, ranks and results.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg   <= now;
            id_reg    <= msg_id;
            coap_reg  <= coap_type;
            slot_reg  <= slot;
            proxy_reg <= (req_type == REQ_STORE_PROXY);
            case (req_type)
                REQ_STORE_CTRL:
                begin
                    kind_reg <= KIND_CTRL;
                    idx_reg  <= ID_ECHO;
                end
                REQ_STORE_PROXY:
                begin
                    kind_reg <= KIND_PROXY;
                    idx_reg  <= ID_ORIG;
                end
                default:
                begin
                    kind_reg <= msg_kind;
                    idx_reg  <= id_index;
                end
            endcase
        end

        if (cmd.scan_step)
        begin
            if (match && better)
            begin
                best_reg      <= cnt_reg;
                best_rank_reg <= order_reg[cnt_reg];
            end
            if (!valid_reg[cnt_reg] && !have_free_reg)
            begin
                free_reg <= cnt_reg;
            end
        end

        // Freeing a slot closes the gap in the insertion ranks.
        if (free_en)
        begin
            for (int j = 0; j < ENTRIES; j++)
            begin
                if (valid_reg[j] && (order_reg[j] > free_rank))
                begin
                    order_reg[j] <= order_reg[j] - 1'b1;
                end
            end
        end

        if (cmd.insert)
        begin
            kind_tab_reg[free_reg] <= kind_reg;
            stamp_reg[free_reg]    <= now_reg;
            order_reg[free_reg]    <= IDX_W'(used_reg);
            if (proxy_reg)
            begin
                coap_tab_reg[free_reg] <= coap_reg;
                first_reg[free_reg]    <= id_reg;
                assigned_reg[free_reg] <= id_counter_reg;
                echo_reg[free_reg]     <= 16'd0;
            end
            else
            begin
                coap_tab_reg[free_reg] <= 2'd0;
                first_reg[free_reg]    <= 16'd0;
                assigned_reg[free_reg] <= 16'd0;
                echo_reg[free_reg]     <= id_reg;
            end
        end

        if (cmd.finish)
        begin
            status_reg <= cmd.status;
            if (cmd.use_entry)
            begin
                hit_slot_reg <= 3'(sel);
                kind_out_reg <= kind_tab_reg[sel];
                coap_out_reg <= coap_tab_reg[sel];
                orig_out_reg <= first_reg[sel];
                new_out_reg  <= assigned_reg[sel];
                echo_out_reg <= echo_reg[sel];
            end
            else
            begin
                hit_slot_reg <= 3'd0;
                kind_out_reg <= 1'b0;
                coap_out_reg <= 2'd0;
                orig_out_reg <= 16'd0;
                new_out_reg  <= 16'd0;
                echo_out_reg <= 16'd0;
            end
        end
    end

    assign done              = done_reg;
    assign status            = status_reg;
    assign hit_slot          = hit_slot_reg;
    assign entry_kind        = kind_out_reg;
    assign entry_coap_type   = coap_out_reg;
    assign entry_original_id = orig_out_reg;
    assign entry_new_id      = new_out_reg;
    assign entry_echoed_id   = echo_out_reg;

endmodule

>>> sv/pending_message_table_with_expiry_core.sv
// Channel   Handshake                       Payload
// request   start, accepted when !busy      req_type now msg_kind msg_id id_index
//                                           coap_type slot
// result    done, one cycle, no stall       status hit_slot entry_kind entry_coap_type
//                                           entry_original_id entry_new_id entry_echoed_id
// config    APB psel/penable/pwrite/pready  paddr pwdata prdata (max_age at 0)
//
// A find or store request walks the table twice, one entry per cycle: an expiry
// sweep, then a match scan that also finds the lowest free slot and counts the
// occupied ones. A store that finds no match while a slot is free then writes a
// new entry; remove, clear and unused codes skip both walks. The result strobe
// rises in the cycle busy falls.
// Reset empties the table, zeroes the ID counter and sets max_age to 1000.
// The receiver cannot stall; each result is shown for exactly one cycle.
module pending_message_table_with_expiry_core
    import pmte_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Request channel.
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [15:0] now,
    input  logic        msg_kind,
    input  logic [15:0] msg_id,
    input  logic [1:0]  id_index,
    input  logic [1:0]  coap_type,
    input  logic [2:0]  slot,

    // Result channel.
    output logic        done,
    output logic [2:0]  status,
    output logic [2:0]  hit_slot,
    output logic        entry_kind,
    output logic [1:0]  entry_coap_type,
    output logic [15:0] entry_original_id,
    output logic [15:0] entry_new_id,
    output logic [15:0] entry_echoed_id,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t        cmd;
    sts_t        sts;
    logic [15:0] max_age;

    // The register file holds the expiry limit. Software must change it only while
    // no request is in flight; the block itself does not enforce this.
    pmte_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_age (max_age)
    );

    // The controller sequences the sweep, the scan and the final insert or
    // result load, or a remove or clear. It decodes the request code only at accept.
    pmte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    // The datapath holds the table, the insertion ranks, the ID counter and
    // the result registers. Freeing an entry lowers every later rank in the same
    // update, so the ranks stay dense and the oldest match has the lowest rank.
    pmte_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .req_type          (req_type),
        .now               (now),
        .msg_kind          (msg_kind),
        .msg_id            (msg_id),
        .id_index          (id_index),
        .coap_type         (coap_type),
        .slot              (slot),
        .max_age           (max_age),
        .done              (done),
        .status            (status),
        .hit_slot          (hit_slot),
        .entry_kind        (entry_kind),
        .entry_coap_type   (entry_coap_type),
        .entry_original_id (entry_original_id),
        .entry_new_id      (entry_new_id),
        .entry_echoed_id   (entry_echoed_id)
    );

endmodule
